// ===== src/kss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_pkg
// Shared sizes, codes and control types of the keyed slot store.
// ----------------------------------------------------------------------------
package kss_pkg;

    localparam int SLOTS       = 4096;
    localparam int ID_BITS     = 64;
    localparam int DIGEST_BITS = 64;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int LEFT_W = $clog2(SLOTS + 1);

    localparam int CMD_BITS        = 3;
    localparam int KEY_ID_BITS     = 64;
    localparam int KEY_DIGEST_BITS = 64;
    localparam int STATUS_BITS     = 2;
    localparam int SLOT_BITS       = 12;
    localparam int COUNT_BITS      = 13;
    localparam int MAX_BITS        = 13;
    localparam int CMP_W           = (CNT_W > MAX_BITS) ? CNT_W : MAX_BITS;

    localparam logic [MAX_BITS-1:0] MAX_RESET = 13'd4096;

    localparam logic [CMD_BITS-1:0] CMD_CLEAR    = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_ADD      = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_FIND_ID  = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_FIND_DIG = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_REM_ID   = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_REM_DIG  = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;

    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_CLEAR,
        FIN_HIT,
        FIN_MISS,
        FIN_FULL
    } fin_t;

    typedef struct packed {
        logic                   occ;
        logic [ID_BITS-1:0]     id;
        logic [DIGEST_BITS-1:0] digest;
    } slot_word_t;

    typedef struct packed {
        logic ready;
        logic scan_load;
        logic scan_en;
        logic clr_en;
        fin_t fin;
    } ctl_t;

    typedef struct packed {
        logic                req_vld;
        logic                hit;
        logic                exhausted;
        logic                clr_last;
        logic                cap_full;
        logic                out_free;
        logic [CMD_BITS-1:0] cmd;
    } sts_t;

endpackage

// ===== src/kss_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_in_if
// Command channel: one word per command with its two keys.
// ----------------------------------------------------------------------------
interface kss_in_if;
    import kss_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_BITS-1:0]        cmd;
    logic [KEY_ID_BITS-1:0]     key_id;
    logic [KEY_DIGEST_BITS-1:0] key_digest;

    modport source (output valid, output cmd, output key_id, output key_digest, input ready);
    modport sink (input valid, input cmd, input key_id, input key_digest, output ready);
endinterface

// ===== src/kss_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_out_if
// Result channel: one word per command with status, slot and count.
// ----------------------------------------------------------------------------
interface kss_out_if;
    import kss_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [SLOT_BITS-1:0]   slot;
    logic [COUNT_BITS-1:0]  count;

    modport source (output valid, output status, output slot, output count, input ready);
    modport sink (input valid, input status, input slot, input count, output ready);
endinterface

// ===== src/kss_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module kss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/kss_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_datapath
// Slot memory, scan pipeline, pointer, count and result register.
// ----------------------------------------------------------------------------
module kss_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [kss_pkg::MAX_BITS-1:0]  cfg_wr_data,
    kss_in_if.sink                        req,
    kss_out_if.source                     rsp,
    input  kss_pkg::ctl_t                 ctl,
    output kss_pkg::sts_t                 sts
);
    import kss_pkg::*;

    function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] a);
        return (a == IDX_W'(SLOTS - 1)) ? '0 : a + 1'b1;
    endfunction

    logic [MAX_BITS-1:0]    max_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       wptr_reg, wptr_next;
    logic [IDX_W-1:0]       scan_addr_reg, scan_addr_next;
    logic [LEFT_W-1:0]      left_reg, left_next;
    logic                   pipe_vld_reg, pipe_vld_next;
    logic                   pipe_last_reg, pipe_last_next;
    logic [IDX_W-1:0]       pipe_addr_reg, pipe_addr_next;
    logic [IDX_W-1:0]       clr_addr_reg, clr_addr_next;
    logic                   rsp_vld_reg, rsp_vld_next;
    logic [STATUS_BITS-1:0] rsp_status_reg, rsp_status_next;
    logic [SLOT_BITS-1:0]   rsp_slot_reg, rsp_slot_next;
    logic [COUNT_BITS-1:0]  rsp_count_reg, rsp_count_next;
    logic [CMD_BITS-1:0]    cmd_reg;
    logic [ID_BITS-1:0]     key_id_reg;
    logic [DIGEST_BITS-1:0] key_dig_reg;

    logic       accept;
    logic       is_add, is_remove, by_dig, match;
    logic       ram_we;
    logic [IDX_W-1:0] ram_waddr;
    slot_word_t ram_wdata, rd_word;

    assign accept    = req.valid && ctl.ready;
    assign req.ready = ctl.ready;

    assign is_add    = (cmd_reg == CMD_ADD);
    assign is_remove = (cmd_reg == CMD_REM_ID) || (cmd_reg == CMD_REM_DIG);
    assign by_dig    = (cmd_reg == CMD_FIND_DIG) || (cmd_reg == CMD_REM_DIG);

    always_comb
    begin
        if (is_add)
        begin
            match = !rd_word.occ;
        end
        else if (by_dig)
        begin
            match = rd_word.occ && (rd_word.digest == key_dig_reg);
        end
        else
        begin
            match = rd_word.occ && (rd_word.id == key_id_reg);
        end
    end

    kss_ram #(
        .WIDTH ($bits(slot_word_t)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_addr_reg),
        .rdata (rd_word)
    );

    always_comb
    begin
        ram_we    = ctl.clr_en || ((ctl.fin == FIN_HIT) && (is_add || is_remove));
        ram_waddr = ctl.clr_en ? clr_addr_reg : pipe_addr_reg;
        if (ctl.clr_en)
        begin
            ram_wdata = '0;
        end
        else
        begin
            ram_wdata.occ    = is_add;
            ram_wdata.id     = key_id_reg;
            ram_wdata.digest = key_dig_reg;
        end
    end

    always_comb
    begin
        scan_addr_next = scan_addr_reg;
        left_next      = left_reg;
        pipe_vld_next  = 1'b0;
        pipe_last_next = pipe_last_reg;
        pipe_addr_next = pipe_addr_reg;
        clr_addr_next  = clr_addr_reg;
        count_next     = count_reg;
        wptr_next      = wptr_reg;
        rsp_vld_next   = rsp_vld_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        rsp_count_next  = rsp_count_reg;

        if (ctl.scan_load)
        begin
            scan_addr_next = is_add ? wptr_reg : '0;
            left_next      = LEFT_W'(SLOTS);
        end
        else if (ctl.scan_en && (left_reg != '0))
        begin
            pipe_vld_next  = 1'b1;
            pipe_addr_next = scan_addr_reg;
            pipe_last_next = (left_reg == LEFT_W'(1));
            scan_addr_next = slot_inc(scan_addr_reg);
            left_next      = left_reg - LEFT_W'(1);
        end

        if (ctl.clr_en)
        begin
            clr_addr_next = slot_inc(clr_addr_reg);
        end

        case (ctl.fin)
            FIN_CLEAR:
            begin
                count_next = '0;
                wptr_next  = '0;
            end
            FIN_HIT:
            begin
                if (is_add)
                begin
                    count_next = count_reg + CNT_W'(1);
                    wptr_next  = pipe_addr_reg;
                end
                else if (is_remove && (count_reg != '0))
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        if (ctl.fin != FIN_NONE)
        begin
            rsp_vld_next   = 1'b1;
            rsp_slot_next  = '0;
            rsp_count_next = COUNT_BITS'(count_next);
            case (ctl.fin)
                FIN_HIT:
                begin
                    rsp_status_next = ST_DONE;
                    rsp_slot_next   = SLOT_BITS'(pipe_addr_reg);
                end
                FIN_MISS:  rsp_status_next = ST_MISSING;
                FIN_FULL:  rsp_status_next = ST_FULL;
                default:   rsp_status_next = ST_DONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= MAX_RESET;
            count_reg     <= '0;
            wptr_reg      <= '0;
            scan_addr_reg <= '0;
            left_reg      <= '0;
            pipe_vld_reg  <= 1'b0;
            clr_addr_reg  <= '0;
            rsp_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_reg <= cfg_wr_data;
            end
            count_reg     <= count_next;
            wptr_reg      <= wptr_next;
            scan_addr_reg <= scan_addr_next;
            left_reg      <= left_next;
            pipe_vld_reg  <= pipe_vld_next;
            clr_addr_reg  <= clr_addr_next;
            rsp_vld_reg   <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_last_reg  <= pipe_last_next;
        pipe_addr_reg  <= pipe_addr_next;
        rsp_status_reg <= rsp_status_next;
        rsp_slot_reg   <= rsp_slot_next;
        rsp_count_reg  <= rsp_count_next;
        if (accept)
        begin
            cmd_reg     <= req.cmd;
            key_id_reg  <= req.key_id[ID_BITS-1:0];
            key_dig_reg <= req.key_digest[DIGEST_BITS-1:0];
        end
    end

    assign rsp.valid  = rsp_vld_reg;
    assign rsp.status = rsp_status_reg;
    assign rsp.slot   = rsp_slot_reg;
    assign rsp.count  = rsp_count_reg;

    assign sts.req_vld   = req.valid;
    assign sts.hit       = pipe_vld_reg && match;
    assign sts.exhausted = pipe_vld_reg && pipe_last_reg && !match;
    assign sts.clr_last  = (clr_addr_reg == IDX_W'(SLOTS - 1));
    assign sts.cap_full  = CMP_W'(count_reg) >= CMP_W'(max_reg);
    assign sts.out_free  = !rsp_vld_reg || rsp.ready;
    assign sts.cmd       = cmd_reg;

endmodule

// ===== src/kss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_ctrl
// Command sequencer: dispatch, slot scan, clear sweep and reset sweep.
// ----------------------------------------------------------------------------
module kss_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  kss_pkg::sts_t sts,
    output kss_pkg::ctl_t ctl
);
    import kss_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_CLEAR
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        ctl        = '0;
        ctl.fin    = FIN_NONE;
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                ctl.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ctl.ready = sts.out_free;
                if (sts.req_vld && sts.out_free)
                begin
                    state_next = S_DISPATCH;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DISPATCH:
            begin
                case (sts.cmd) inside
                    CMD_CLEAR:
                    begin
                        state_next = S_CLEAR;
                    end
                    CMD_ADD:
                    begin
                        if (sts.cap_full)
                        begin
                            ctl.fin    = FIN_FULL;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            ctl.scan_load = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    CMD_FIND_ID, CMD_FIND_DIG, CMD_REM_ID, CMD_REM_DIG:
                    begin
                        ctl.scan_load = 1'b1;
                        state_next    = S_SCAN;
                    end
                    default:
                    begin
                        ctl.fin    = FIN_MISS;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                ctl.scan_en = 1'b1;
                if (sts.hit)
                begin
                    ctl.fin    = FIN_HIT;
                    state_next = S_IDLE;
                end
                else if (sts.exhausted)
                begin
                    ctl.fin    = (sts.cmd == CMD_ADD) ? FIN_FULL : FIN_MISS;
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                ctl.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    ctl.fin    = FIN_CLEAR;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/keyed_slot_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_store
// Slot allocator with an occupancy bit per slot and sequential key search.
//
// Channel   Role    Word contents
// req       sink    cmd, key_id, key_digest
// rsp       source  status, slot, count
// cfg       write   max_records (cfg_wr_en, cfg_wr_data)
//
// Add, find and remove scan the slot memory one slot per cycle; an add refused
// by the record limit and an unused code are answered without a scan. Clear
// sweeps the memory. After reset a sweep clears the memory before the first
// command is taken. One command is in flight at a time, and the next is taken
// once the result register is free or is being read.
// ----------------------------------------------------------------------------
module keyed_slot_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [kss_pkg::MAX_BITS-1:0] cfg_wr_data,
    kss_in_if.sink                       req,
    kss_out_if.source                    rsp
);
    import kss_pkg::*;

    ctl_t ctl;
    sts_t sts;

    kss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    kss_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .rsp         (rsp),
        .ctl         (ctl),
        .sts         (sts)
    );

endmodule
